FILE: rtl/positional_list_store_unit_macros.svh
// ----------------------------------------------------------------------------
// positional_list_store_unit assertion macros
// Shared wrappers for the concurrent checks on the list store ports.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_STORE_UNIT_MACROS_SVH
`define POSITIONAL_LIST_STORE_UNIT_MACROS_SVH

// Check sampled on aclk, skipped while reset is held
`define PLSU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check sampled on aclk, active during reset as well
`define PLSU_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

FILE: rtl/plsu_pkg.sv
// ----------------------------------------------------------------------------
// plsu_pkg
// Field widths, request kinds, status codes and cell control for the list store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package plsu_pkg;

    localparam int KIND_W = 3;
    localparam int POS_W  = 5;
    localparam int WORD_W = 32;
    localparam int ST_W   = 2;
    localparam int CNT_W  = 5;
    localparam int IN_W   = 40;
    localparam int OUT_W  = 40;

    localparam logic [KIND_W-1:0] KIND_INSERT = 3'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd1;
    localparam logic [KIND_W-1:0] KIND_READ   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_APPEND = 3'd3;
    localparam logic [KIND_W-1:0] KIND_POP    = 3'd4;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd5;

    localparam logic [ST_W-1:0] ST_OK     = 2'd0;
    localparam logic [ST_W-1:0] ST_BADPOS = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY  = 2'd2;
    localparam logic [ST_W-1:0] ST_FULL   = 2'd3;

    // Broadcast to every cell of the chain
    typedef struct packed {
        logic ins;
        logic rem;
    } plsu_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/plsu_cell.sv
// ----------------------------------------------------------------------------
// plsu_cell
// One slot of the list: holds a word, takes the left or right neighbour on a shift.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module plsu_cell #(
    parameter int IDX = 0,
    parameter int PW  = 5
) (
    input  wire logic                        aclk,
    input  wire plsu_pkg::plsu_ctl_t         ctl,
    input  wire logic [PW-1:0]               pos,
    input  wire logic [plsu_pkg::WORD_W-1:0] value,
    input  wire logic [plsu_pkg::WORD_W-1:0] left,
    input  wire logic [plsu_pkg::WORD_W-1:0] right,
    output logic      [plsu_pkg::WORD_W-1:0] q
);
    import plsu_pkg::*;

    localparam logic [PW-1:0] MY_IDX = PW'(IDX);

    logic [WORD_W-1:0] entry_reg;
    logic [WORD_W-1:0] entry_next;
    logic              above;
    logic              at_pos;

    assign above  = MY_IDX > pos;
    assign at_pos = MY_IDX == pos;

    always_comb begin
        entry_next = entry_reg;
        if (ctl.ins) begin
            if (at_pos) begin
                entry_next = value;
            end else if (above) begin
                entry_next = left;
            end
        end else if (ctl.rem) begin
            // close the gap: every slot from the position up takes its upper neighbour
            if (above || at_pos) begin
                entry_next = right;
            end
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign q = entry_reg;

endmodule

`default_nettype wire

FILE: rtl/positional_list_store_unit.sv
// The result word is written to the output register in the cycle after its request is taken.
// Throughput: one request per cycle while s_tready is high; all DEPTH cells shift in parallel.
// s_tready stays high while the output register is empty or being drained.
// Reset clears the stored count and the output valid; the stored words are not cleared.
// No clearing pass is run after reset.
// ----------------------------------------------------------------------------
// positional_list_store_unit
// Ordered word list with insert, remove, read, append, pop and clear at a position.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module positional_list_store_unit #(
    parameter int DEPTH = 16
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    // kind[2:0], position[7:3], value[39:8]
    input  wire logic [plsu_pkg::IN_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    // status[1:0], data[33:2], count[38:34], empty_res[39]
    output logic      [plsu_pkg::OUT_W-1:0] m_tdata
);
    import plsu_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > POS_W) ? CW : POS_W;

    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0]  position;
    logic [WORD_W-1:0] value;

    logic [CW-1:0]     cnt_reg;
    logic [CW-1:0]     cnt_next;
    logic              m_tvalid_reg;
    logic [OUT_W-1:0]  m_tdata_reg;

    logic              accept;
    logic [XW-1:0]     pos_x;
    logic [XW-1:0]     cnt_x;
    logic [XW-1:0]     tgt;
    logic              is_empty;
    logic              is_full;
    logic [ST_W-1:0]   status;
    logic              rd_en;
    plsu_ctl_t         ctl;
    plsu_ctl_t         ctl_q;
    logic [WORD_W-1:0] rd_word;
    logic [WORD_W-1:0] data;
    logic [WORD_W-1:0] q [DEPTH];

    assign kind     = s_tdata[KIND_W-1:0];
    assign position = s_tdata[KIND_W+POS_W-1:KIND_W];
    assign value    = s_tdata[KIND_W+POS_W+WORD_W-1:KIND_W+POS_W];

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign pos_x    = XW'(position);
    assign cnt_x    = XW'(cnt_reg);
    assign is_empty = cnt_reg == '0;
    assign is_full  = cnt_x == XW'(DEPTH);

    always_comb begin
        status   = ST_OK;
        rd_en    = 1'b0;
        ctl      = '0;
        tgt      = pos_x;
        cnt_next = cnt_reg;
        case (kind)
            KIND_INSERT: begin
                if (pos_x > cnt_x) begin
                    status = ST_BADPOS;
                end else if (is_full) begin
                    status = ST_FULL;
                end else begin
                    ctl.ins  = 1'b1;
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            KIND_REMOVE, KIND_READ: begin
                if (is_empty) begin
                    status = ST_EMPTY;
                end else if (pos_x >= cnt_x) begin
                    status = ST_BADPOS;
                end else begin
                    rd_en = 1'b1;
                    if (kind == KIND_REMOVE) begin
                        ctl.rem  = 1'b1;
                        cnt_next = cnt_reg - CW'(1);
                    end
                end
            end
            KIND_APPEND: begin
                tgt = cnt_x;
                if (is_full) begin
                    status = ST_FULL;
                end else begin
                    ctl.ins  = 1'b1;
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            KIND_POP: begin
                tgt = cnt_x - XW'(1);
                if (is_empty) begin
                    status = ST_EMPTY;
                end else begin
                    rd_en    = 1'b1;
                    ctl.rem  = 1'b1;
                    cnt_next = cnt_reg - CW'(1);
                end
            end
            KIND_CLEAR: begin
                cnt_next = '0;
            end
            default: begin
            end
        endcase
    end

    // cells move only on a taken request
    assign ctl_q = accept ? ctl : '0;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [WORD_W-1:0] left_w;
        logic [WORD_W-1:0] right_w;
        if (i == 0) begin : g_first
            assign left_w = '0;
        end else begin : g_mid_l
            assign left_w = q[i-1];
        end
        if (i == DEPTH - 1) begin : g_last
            assign right_w = q[i];
        end else begin : g_mid_r
            assign right_w = q[i+1];
        end
        plsu_cell #(
            .IDX (i),
            .PW  (XW)
        ) u_cell (
            .aclk  (aclk),
            .ctl   (ctl_q),
            .pos   (tgt),
            .value (value),
            .left  (left_w),
            .right (right_w),
            .q     (q[i])
        );
    end

    always_comb begin
        rd_word = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (XW'(i) == tgt) begin
                rd_word = rd_word | q[i];
            end
        end
    end

    assign data = rd_en ? rd_word : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (accept) begin
                cnt_reg      <= cnt_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // hold the result word until the sink takes it
    always_ff @(posedge aclk) begin
        if (accept) begin
            m_tdata_reg <= {cnt_next == '0, CNT_W'(cnt_next), data, status};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

FILE: rtl/plsu_checker.sv
// ----------------------------------------------------------------------------
// plsu_checker
// Port-level checks on the list store, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "positional_list_store_unit_macros.svh"

module plsu_checker #(
    parameter int DEPTH = 16
) (
    input wire logic                       aclk,
    input wire logic                       aresetn,
    input wire logic                       s_tvalid,
    input wire logic                       s_tready,
    input wire logic [plsu_pkg::IN_W-1:0]  s_tdata,
    input wire logic                       m_tvalid,
    input wire logic                       m_tready,
    input wire logic [plsu_pkg::OUT_W-1:0] m_tdata
);
    import plsu_pkg::*;

    `PLSU_ASSERT_ALWAYS(a_rst_clears_valid, !aresetn |=> !m_tvalid, "valid not cleared by reset")
    `PLSU_ASSERT(a_stall_holds, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled word changed")
    `PLSU_ASSERT(a_take_gives_word, s_tvalid && s_tready |=> m_tvalid, "request taken but no result")
    `PLSU_ASSERT(a_clear_result, s_tvalid && s_tready && s_tdata[KIND_W-1:0] == KIND_CLEAR |=> m_tdata[ST_W-1:0] == ST_OK && m_tdata[OUT_W-1], "clear result not ok and empty")
    `PLSU_ASSERT(a_empty_flag, m_tvalid && DEPTH < 32 |-> m_tdata[OUT_W-1] == (m_tdata[OUT_W-2:OUT_W-1-CNT_W] == '0), "empty flag disagrees with count")

endmodule

bind positional_list_store_unit plsu_checker #(.DEPTH(DEPTH)) u_plsu_checker (.*);

`default_nettype wire
